### hw/rtl/pmp_pkg.sv
// Shared types, constants and codes for the phase map projector point block.
// No dependencies; every other file but pmp_ram refers to it by scoped names.
`default_nettype none
package pmp_pkg;
  localparam int MAP_COLS = 512;
  localparam int MAP_ROWS = 512;
  localparam int COORD_FRAC_BITS = 8;
  localparam int COL_W = $clog2(MAP_COLS);
  localparam int ROW_W = $clog2(MAP_ROWS);
  localparam int BANK_AW = COL_W - 1 + ROW_W - 1;
  localparam int BANK_DEPTH = 1 << BANK_AW;
  localparam int CAM_W = 19;
  localparam int X0_W = CAM_W - 1 - COORD_FRAC_BITS;
  localparam int PH_W = 32;
  localparam int WT_W = COORD_FRAC_BITS + 1;
  localparam int TOP_W = PH_W + WT_W + 2;
  localparam int P_W = TOP_W + WT_W + 2;
  localparam int SCALE_W = 28;
  localparam int PROD_W = PH_W + SCALE_W;
  localparam int RES_W = PROD_W - 24;
  localparam int OUT_W = 20;

  typedef enum logic [1:0] {
    CMD_WRITE_X = 2'd0,
    CMD_WRITE_Y = 2'd1,
    CMD_QUERY   = 2'd2,
    CMD_NONE    = 2'd3
  } pmp_cmd_t;

  typedef enum logic [2:0] {
    REG_MAP_COLS    = 3'd0,
    REG_MAP_ROWS    = 3'd1,
    REG_PROJ_WIDTH  = 3'd2,
    REG_PROJ_HEIGHT = 3'd3,
    REG_X_SCALE     = 3'd4,
    REG_Y_SCALE     = 3'd5
  } pmp_reg_t;

  typedef struct packed {
    logic signed [PH_W-1:0] p00;
    logic signed [PH_W-1:0] p10;
    logic signed [PH_W-1:0] p01;
    logic signed [PH_W-1:0] p11;
    logic                   finite;
  } pmp_nbr_t;
endpackage
`default_nettype wire

### hw/rtl/phase_map_projector_point.sv
// Top level of the phase map projector point block: registers, map stores,
// query pipeline. Depends on pmp_pkg, pmp_map and pmp_axis.
//
// Takes one beat per cycle (busy stays low). Pixel writes give no result; a
// query gives one result beat on done after the banked map read and five
// arithmetic stages (blend, blend, round, scale, range check). The receiver
// cannot stall, so results are never held. A pixel written in one cycle is
// seen by a query taken in the next.
`default_nettype none
module phase_map_projector_point (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    command,
  input  wire logic [8:0]                    pixel_col,
  input  wire logic [8:0]                    pixel_row,
  input  wire logic signed [31:0]            phase_value,
  input  wire logic                          phase_finite,
  input  wire logic signed [18:0]            cam_x,
  input  wire logic signed [18:0]            cam_y,
  input  wire logic                          cfg_we,
  input  wire logic [2:0]                    cfg_index,
  input  wire logic [27:0]                   cfg_data,
  output logic                               done,
  output logic [19:0]                        proj_x,
  output logic [19:0]                        proj_y,
  output logic                               point_valid
);
  localparam int F = pmp_pkg::COORD_FRAC_BITS;

  logic [9:0] map_cols, map_rows;
  logic [11:0] proj_width, proj_height;
  logic [27:0] x_scale, y_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_cols <= 10'd512;
      map_rows <= 10'd512;
      proj_width <= 12'd1920;
      proj_height <= 12'd1080;
      x_scale <= 28'd20026328;
      y_scale <= 28'd11264787;
    end else if (cfg_we) begin
      case (cfg_index)
        pmp_pkg::REG_MAP_COLS: map_cols <= cfg_data[9:0];
        pmp_pkg::REG_MAP_ROWS: map_rows <= cfg_data[9:0];
        pmp_pkg::REG_PROJ_WIDTH: proj_width <= cfg_data[11:0];
        pmp_pkg::REG_PROJ_HEIGHT: proj_height <= cfg_data[11:0];
        pmp_pkg::REG_X_SCALE: x_scale <= cfg_data;
        pmp_pkg::REG_Y_SCALE: y_scale <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic accept, wr_ok, wr_x, wr_y, query;
  logic [pmp_pkg::X0_W-1:0] x0, y0;
  logic [pmp_pkg::X0_W:0] cols, rows;
  logic in_map;

  assign accept = start && !busy;
  assign wr_ok = (32'(pixel_col) < pmp_pkg::MAP_COLS) && (32'(pixel_row) < pmp_pkg::MAP_ROWS);
  assign wr_x = accept && wr_ok && (command == pmp_pkg::CMD_WRITE_X);
  assign wr_y = accept && wr_ok && (command == pmp_pkg::CMD_WRITE_Y);
  assign query = accept && (command == pmp_pkg::CMD_QUERY);
  assign x0 = cam_x[F +: pmp_pkg::X0_W];
  assign y0 = cam_y[F +: pmp_pkg::X0_W];
  assign cols = (32'(map_cols) < pmp_pkg::MAP_COLS) ? (pmp_pkg::X0_W+1)'(map_cols)
                                                    : (pmp_pkg::X0_W+1)'(pmp_pkg::MAP_COLS);
  assign rows = (32'(map_rows) < pmp_pkg::MAP_ROWS) ? (pmp_pkg::X0_W+1)'(map_rows)
                                                    : (pmp_pkg::X0_W+1)'(pmp_pkg::MAP_ROWS);
  assign in_map = !cam_x[18] && !cam_y[18] &&
                  (({1'b0, x0} + 1'b1) < cols) && (({1'b0, y0} + 1'b1) < rows);

  logic [5:1] vld;
  logic [5:1] ok;
  logic selx, sely;
  logic [F-1:0] dx1, dy1;
  pmp_pkg::pmp_nbr_t nbr_x, nbr_y;
  logic [pmp_pkg::RES_W-1:0] res_x, res_y;
  logic bad_x, bad_y, good;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      done <= 1'b0;
    end else begin
      vld <= {vld[4:1], query};
      done <= vld[5];
    end
  end

  always_ff @(posedge clk) begin
    ok <= {ok[4:2], ok[1] & nbr_x.finite & nbr_y.finite, in_map};
    selx <= x0[0];
    sely <= y0[0];
    dx1 <= cam_x[F-1:0];
    dy1 <= cam_y[F-1:0];
    point_valid <= good;
    proj_x <= good ? res_x[19:0] : '0;
    proj_y <= good ? res_y[19:0] : '0;
  end

  pmp_map u_map_x (
    .clk(clk), .we(wr_x),
    .wcol(pixel_col[pmp_pkg::COL_W-1:0]), .wrow(pixel_row[pmp_pkg::ROW_W-1:0]),
    .wdata({phase_finite, phase_value}),
    .x0(x0[pmp_pkg::COL_W-1:0]), .y0(y0[pmp_pkg::ROW_W-1:0]),
    .selx(selx), .sely(sely), .nbr(nbr_x)
  );

  pmp_map u_map_y (
    .clk(clk), .we(wr_y),
    .wcol(pixel_col[pmp_pkg::COL_W-1:0]), .wrow(pixel_row[pmp_pkg::ROW_W-1:0]),
    .wdata({phase_finite, phase_value}),
    .x0(x0[pmp_pkg::COL_W-1:0]), .y0(y0[pmp_pkg::ROW_W-1:0]),
    .selx(selx), .sely(sely), .nbr(nbr_y)
  );

  pmp_axis u_axis_x (
    .clk(clk), .nbr(nbr_x), .dx(dx1), .dy(dy1), .scale(x_scale),
    .res(res_x), .bad(bad_x)
  );

  pmp_axis u_axis_y (
    .clk(clk), .nbr(nbr_y), .dx(dx1), .dy(dy1), .scale(y_scale),
    .res(res_y), .bad(bad_y)
  );

  assign good = ok[5] && !bad_x && !bad_y &&
                (res_x < pmp_pkg::RES_W'({proj_width, 8'b0})) &&
                (res_y < pmp_pkg::RES_W'({proj_height, 8'b0}));

`ifndef SYNTHESIS
  a_query_latency: assert property (@(posedge clk) disable iff (rst)
    query |-> ##6 done) else $error("query beat without result");
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> vld[5] == 1'b0 || $past(vld[5])) else $error("result without query");
  a_invalid_zero: assert property (@(posedge clk)
    (done && !point_valid) |-> (proj_x == '0 && proj_y == '0))
    else $error("invalid result carries coordinates");
  a_valid_inside: assert property (@(posedge clk)
    (done && point_valid) |-> (32'(proj_x) < (32'(proj_width) << 8)))
    else $error("valid point outside projector");
`endif
endmodule
`default_nettype wire

### hw/rtl/pmp_ram.sv
// Generic single write, single read RAM with registered read data.
// No dependencies.
`default_nettype none
module pmp_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8,
  parameter int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### hw/rtl/pmp_map.sv
// One phase map, split into four banks by row and column parity so that all
// four cells of a 2x2 neighbourhood read at once. Depends on pmp_pkg and pmp_ram.
`default_nettype none
module pmp_map (
  input  wire logic                    clk,
  input  wire logic                    we,
  input  wire logic [pmp_pkg::COL_W-1:0] wcol,
  input  wire logic [pmp_pkg::ROW_W-1:0] wrow,
  input  wire logic [pmp_pkg::PH_W:0]  wdata,
  input  wire logic [pmp_pkg::COL_W-1:0] x0,
  input  wire logic [pmp_pkg::ROW_W-1:0] y0,
  input  wire logic                    selx,
  input  wire logic                    sely,
  output pmp_pkg::pmp_nbr_t            nbr
);
  logic [pmp_pkg::PH_W:0] rd [4];

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic BC = 1'(b % 2);
    localparam logic BR = 1'(b / 2);
    logic [pmp_pkg::COL_W:0] csum;
    logic [pmp_pkg::ROW_W:0] rsum;
    logic [pmp_pkg::BANK_AW-1:0] raddr;
    logic bwe;
    assign csum = {1'b0, x0} + (pmp_pkg::COL_W+1)'(x0[0] ^ BC);
    assign rsum = {1'b0, y0} + (pmp_pkg::ROW_W+1)'(y0[0] ^ BR);
    assign raddr = {rsum[pmp_pkg::ROW_W-1:1], csum[pmp_pkg::COL_W-1:1]};
    assign bwe = we && (wrow[0] == BR) && (wcol[0] == BC);
    pmp_ram #(
      .DEPTH(pmp_pkg::BANK_DEPTH),
      .WIDTH(pmp_pkg::PH_W + 1)
    ) u_ram (
      .clk  (clk),
      .we   (bwe),
      .waddr({wrow[pmp_pkg::ROW_W-1:1], wcol[pmp_pkg::COL_W-1:1]}),
      .wdata(wdata),
      .raddr(raddr),
      .rdata(rd[b])
    );
  end

  logic [pmp_pkg::PH_W:0] e00, e10, e01, e11;

  always_comb begin
    e00 = rd[{sely, selx}];
    e10 = rd[{sely, ~selx}];
    e01 = rd[{~sely, selx}];
    e11 = rd[{~sely, ~selx}];
    nbr.p00 = e00[pmp_pkg::PH_W-1:0];
    nbr.p10 = e10[pmp_pkg::PH_W-1:0];
    nbr.p01 = e01[pmp_pkg::PH_W-1:0];
    nbr.p11 = e11[pmp_pkg::PH_W-1:0];
    nbr.finite = e00[pmp_pkg::PH_W] & e10[pmp_pkg::PH_W] & e01[pmp_pkg::PH_W] &
                 e11[pmp_pkg::PH_W];
  end
endmodule
`default_nettype wire

### hw/rtl/pmp_axis.sv
// Bilinear blend, rounding and scaling of one phase map, four register stages.
// Depends on pmp_pkg.
`default_nettype none
module pmp_axis (
  input  wire logic                                clk,
  input  wire pmp_pkg::pmp_nbr_t                   nbr,
  input  wire logic [pmp_pkg::COORD_FRAC_BITS-1:0] dx,
  input  wire logic [pmp_pkg::COORD_FRAC_BITS-1:0] dy,
  input  wire logic [pmp_pkg::SCALE_W-1:0]         scale,
  output logic      [pmp_pkg::RES_W-1:0]           res,
  output logic                                     bad
);
  localparam int F = pmp_pkg::COORD_FRAC_BITS;
  localparam logic [pmp_pkg::WT_W-1:0] ONE = pmp_pkg::WT_W'(1 << F);
  localparam logic [pmp_pkg::P_W-1:0] P_HALF = pmp_pkg::P_W'(1) << (2 * F - 1);
  localparam logic [pmp_pkg::PROD_W-1:0] R_HALF = pmp_pkg::PROD_W'(1) << 23;

  logic signed [pmp_pkg::WT_W:0] wx0, wx1, wy0, wy1;
  logic signed [pmp_pkg::TOP_W-1:0] m00, m10, m01, m11;
  logic signed [pmp_pkg::TOP_W-1:0] top, bot;
  logic signed [pmp_pkg::P_W-1:0] mt, mb;
  logic [F-1:0] dy2;
  logic signed [pmp_pkg::P_W-1:0] p;
  logic [pmp_pkg::P_W-1:0] p_rnd;
  logic [pmp_pkg::PH_W-1:0] q;
  logic neg4, neg5;
  logic [pmp_pkg::PROD_W-1:0] prod, prod_rnd;

  assign wx0 = $signed({1'b0, ONE - pmp_pkg::WT_W'(dx)});
  assign wx1 = $signed({2'b0, dx});
  assign wy0 = $signed({1'b0, ONE - pmp_pkg::WT_W'(dy2)});
  assign wy1 = $signed({2'b0, dy2});
  assign m00 = $signed(nbr.p00) * wx0;
  assign m10 = $signed(nbr.p10) * wx1;
  assign m01 = $signed(nbr.p01) * wx0;
  assign m11 = $signed(nbr.p11) * wx1;
  assign mt = top * wy0;
  assign mb = bot * wy1;
  assign p_rnd = $unsigned(p) + P_HALF;
  assign prod_rnd = prod + R_HALF;

  always_ff @(posedge clk) begin
    top <= m00 + m10;
    bot <= m01 + m11;
    dy2 <= dy;
    p <= mt + mb;
    neg4 <= p[pmp_pkg::P_W-1];
    q <= p[pmp_pkg::P_W-1] ? '0 : p_rnd[2*F +: pmp_pkg::PH_W];
    neg5 <= neg4;
    prod <= pmp_pkg::PROD_W'(q) * pmp_pkg::PROD_W'(scale);
  end

  assign res = prod_rnd[pmp_pkg::PROD_W-1:24];
  assign bad = neg5 && (scale != '0);
endmodule
`default_nettype wire

### tb/sv/phase_map_projector_point_tb.sv
// Testbench for phase_map_projector_point: loads both phase maps, sends queries and
// checks each result beat against an in-bench bilinear lookup predictor.
// Depends on pmp_pkg and the phase_map_projector_point RTL.
`timescale 1ns / 1ps
module phase_map_projector_point_tb;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 10;
  localparam int RANDOM_ITEMS = 1150;

  typedef struct packed {
    logic [19:0] px;
    logic [19:0] py;
    logic        pv;
  } proj_point_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] command = '0;
  logic [8:0] pixel_col = '0;
  logic [8:0] pixel_row = '0;
  logic signed [31:0] phase_value = '0;
  logic phase_finite = 1'b0;
  logic signed [18:0] cam_x = '0;
  logic signed [18:0] cam_y = '0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [27:0] cfg_data = '0;
  logic done;
  logic [19:0] proj_x;
  logic [19:0] proj_y;
  logic point_valid;

  phase_map_projector_point uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .command(command),
    .pixel_col(pixel_col), .pixel_row(pixel_row), .phase_value(phase_value),
    .phase_finite(phase_finite), .cam_x(cam_x), .cam_y(cam_y), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .done(done), .proj_x(proj_x),
    .proj_y(proj_y), .point_valid(point_valid)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // predictor state
  logic [32:0] x_map [int];
  logic [32:0] y_map [int];
  bit loaded_cell [int];
  int loaded_list [$];
  int unsigned lim_cols = 512, lim_rows = 512, lim_width = 1920, lim_height = 1080;
  longint unsigned scale_x = 20026328, scale_y = 11264787;
  proj_point_t expected_points [$];

  int mismatches = 0;
  int points_checked = 0;
  int valid_points = 0;
  int beats_sent = 0;
  int idle_cycles = 0;
  bit no_gaps = 1'b0;

  function automatic bit blend_map(input bit is_y, input int x0, input int y0,
                                   input longint dx, input longint dy,
                                   output longint p);
    int base;
    logic [32:0] e [4];
    longint v [4];
    base = y0 * pmp_pkg::MAP_COLS + x0;
    for (int k = 0; k < 4; k++) begin
      int a;
      a = base + (k % 2) + (k / 2) * pmp_pkg::MAP_COLS;
      if (is_y) e[k] = y_map.exists(a) ? y_map[a] : 33'd0;
      else e[k] = x_map.exists(a) ? x_map[a] : 33'd0;
      v[k] = longint'($signed(e[k][31:0]));
    end
    p = (v[0] * (256 - dx) + v[1] * dx) * (256 - dy) + (v[2] * (256 - dx) + v[3] * dx) * dy;
    return e[0][32] && e[1][32] && e[2][32] && e[3][32];
  endfunction

  function automatic bit scale_blend(input longint p, input longint unsigned s,
                                     output longint unsigned r);
    longint unsigned q;
    if (p < 0) begin
      r = 0;
      return s == 0;
    end
    q = (longint'(p) + (64'd1 << 15)) >> 16;
    r = (q * s + (64'd1 << 23)) >> 24;
    return 1'b1;
  endfunction

  function automatic proj_point_t project_point(input logic [18:0] cx, input logic [18:0] cy);
    proj_point_t r;
    longint sx, sy, px, py;
    longint unsigned rx, ry;
    int x0, y0, cols, rows;
    bit ok;
    r = '0;
    sx = longint'($signed(cx));
    sy = longint'($signed(cy));
    cols = lim_cols < pmp_pkg::MAP_COLS ? lim_cols : pmp_pkg::MAP_COLS;
    rows = lim_rows < pmp_pkg::MAP_ROWS ? lim_rows : pmp_pkg::MAP_ROWS;
    if (sx < 0 || sy < 0) return r;
    x0 = int'(sx >> 8);
    y0 = int'(sy >> 8);
    if (x0 + 1 >= cols || y0 + 1 >= rows) return r;
    ok = blend_map(1'b0, x0, y0, sx & 255, sy & 255, px);
    ok = ok && blend_map(1'b1, x0, y0, sx & 255, sy & 255, py);
    ok = ok && scale_blend(px, scale_x, rx) && scale_blend(py, scale_y, ry);
    ok = ok && rx < (longint'(lim_width) << 8) && ry < (longint'(lim_height) << 8);
    if (ok) begin
      r.px = rx[19:0];
      r.py = ry[19:0];
      r.pv = 1'b1;
    end
    return r;
  endfunction

  // check results, then track accepted beats and register writes
  always @(posedge clk) begin
    if (done) begin
      proj_point_t got, want;
      got = '{proj_x, proj_y, point_valid};
      if (expected_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h at %0t", got, $time);
      end else begin
        want = expected_points.pop_front();
        points_checked++;
        if (got.pv) valid_points++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at %0t: x %h/%h y %h/%h valid %b/%b (expected/actual)",
                     $time, want.px, got.px, want.py, got.py, want.pv, got.pv);
        end
      end
    end
    if (!rst && cfg_we) begin
      case (pmp_pkg::pmp_reg_t'(cfg_index))
        pmp_pkg::REG_MAP_COLS:    lim_cols = cfg_data[9:0];
        pmp_pkg::REG_MAP_ROWS:    lim_rows = cfg_data[9:0];
        pmp_pkg::REG_PROJ_WIDTH:  lim_width = cfg_data[11:0];
        pmp_pkg::REG_PROJ_HEIGHT: lim_height = cfg_data[11:0];
        pmp_pkg::REG_X_SCALE:     scale_x = cfg_data;
        pmp_pkg::REG_Y_SCALE:     scale_y = cfg_data;
        default: ;
      endcase
    end
    if (!rst && start && !busy) begin
      case (pmp_pkg::pmp_cmd_t'(command))
        pmp_pkg::CMD_WRITE_X:
          x_map[pixel_row * pmp_pkg::MAP_COLS + pixel_col] = {phase_finite, phase_value};
        pmp_pkg::CMD_WRITE_Y:
          y_map[pixel_row * pmp_pkg::MAP_COLS + pixel_col] = {phase_finite, phase_value};
        pmp_pkg::CMD_QUERY:
          expected_points = {expected_points, project_point(cam_x, cam_y)};
        default: ;
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired at %0t", $time);
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // called at a falling edge; returns at a falling edge
  task automatic send_beat(input pmp_pkg::pmp_cmd_t cmd, input logic [8:0] col,
                           input logic [8:0] row, input logic [31:0] val, input logic fin,
                           input logic [18:0] cx, input logic [18:0] cy);
    int gap;
    command <= cmd;
    pixel_col <= col;
    pixel_row <= row;
    phase_value <= val;
    phase_finite <= fin;
    cam_x <= cx;
    cam_y <= cy;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    beats_sent++;
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic query_point(input int x0, input int y0, input int dx, input int dy);
    send_beat(pmp_pkg::CMD_QUERY, '0, '0, $urandom, 1'($urandom_range(0, 1)),
              19'(x0 * 256 + dx), 19'(y0 * 256 + dy));
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (expected_points.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input pmp_pkg::pmp_reg_t idx, input logic [27:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_regs(input int cols, input int rows, input int w, input int h,
                          input logic [27:0] sx, input logic [27:0] sy);
    wait_idle();
    write_reg(pmp_pkg::REG_MAP_COLS, 28'(cols));
    write_reg(pmp_pkg::REG_MAP_ROWS, 28'(rows));
    write_reg(pmp_pkg::REG_PROJ_WIDTH, 28'(w));
    write_reg(pmp_pkg::REG_PROJ_HEIGHT, 28'(h));
    write_reg(pmp_pkg::REG_X_SCALE, sx);
    write_reg(pmp_pkg::REG_Y_SCALE, sy);
  endtask

  function automatic logic [31:0] pick_phase();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return $urandom;
    if (r == 1) return -$urandom_range(1, 1 << 18);
    return $urandom_range(0, 1 << 19);
  endfunction

  // load all four neighbours of a cell in both maps
  task automatic load_cell(input int x0, input int y0, input bit all_finite);
    logic [31:0] base;
    for (int m = 0; m < 2; m++) begin
      base = pick_phase();
      for (int k = 0; k < 4; k++) begin
        logic [31:0] v;
        v = ($urandom_range(0, 15) == 0) ? $urandom : base + $urandom_range(0, 4096) - 2048;
        send_beat(m ? pmp_pkg::CMD_WRITE_Y : pmp_pkg::CMD_WRITE_X, 9'(x0 + k % 2),
                  9'(y0 + k / 2), v, all_finite || $urandom_range(0, 19) != 0, '0, '0);
      end
    end
    if (!loaded_cell.exists(y0 * pmp_pkg::MAP_COLS + x0)) begin
      loaded_cell[y0 * pmp_pkg::MAP_COLS + x0] = 1'b1;
      loaded_list = {loaded_list, y0 * pmp_pkg::MAP_COLS + x0};
    end
  endtask

  task automatic test_directed();
    load_cell(510, 510, 1'b1);
    send_beat(pmp_pkg::CMD_WRITE_X, 9'd511, 9'd511, 32'h7FFF_FFFF, 1'b1, '0, '0);
    query_point(510, 510, 0, 0);
    query_point(510, 510, 255, 255);
    load_cell(0, 0, 1'b1);
    query_point(0, 0, 128, 0);
    send_beat(pmp_pkg::CMD_WRITE_Y, 9'd1, 9'd1, 32'h8000_0000, 1'b0, '0, '0);
    query_point(0, 0, 1, 1);
    send_beat(pmp_pkg::CMD_NONE, 9'h1FF, 9'h1FF, $urandom, 1'b1, 19'h3FFFF, 19'h3FFFF);
    send_beat(pmp_pkg::CMD_QUERY, '0, '0, '0, 1'b0, 19'h40000, 19'h00100);
    send_beat(pmp_pkg::CMD_QUERY, '0, '0, '0, 1'b0, 19'h3FFFF, 19'h3FFFF);
    query_point(511, 0, 0, 0);
  endtask

  task automatic test_register_extremes();
    set_regs(2, 2, 1, 1, 28'd0, 28'd0);
    query_point(0, 0, 17, 200);
    query_point(510, 510, 3, 3);
    set_regs(1023, 1023, 4095, 4095, 28'hFFF_FFFF, 28'hFFF_FFFF);
    query_point(510, 510, 255, 0);
    query_point(0, 0, 0, 0);
  endtask

  task automatic random_burst(input int n);
    int target;
    target = beats_sent + n;
    while (beats_sent < target) begin
      int r, x0, y0, c;
      r = $urandom_range(0, 99);
      if (r < 75) begin
        if ($urandom_range(0, 9) < 7) begin
          x0 = $urandom_range(0, 31);
          y0 = $urandom_range(0, 31);
        end else begin
          x0 = $urandom_range(0, 510);
          y0 = $urandom_range(0, 510);
        end
        load_cell(x0, y0, $urandom_range(0, 3) != 0);
        repeat ($urandom_range(1, 5)) begin
          if ($urandom_range(0, 2) == 0) begin
            c = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
            query_point(c % pmp_pkg::MAP_COLS, c / pmp_pkg::MAP_COLS, $urandom_range(0, 255),
                        $urandom_range(0, 255));
          end else begin
            query_point(x0, y0, $urandom_range(0, 255), $urandom_range(0, 255));
          end
        end
      end else if (r < 85) begin
        send_beat(pmp_pkg::CMD_QUERY, 9'($urandom), 9'($urandom), $urandom,
                  1'($urandom_range(0, 1)),
                  19'($urandom_range(0, 1 << 18) | (1 << 18)), 19'($urandom));
      end else if (r < 92) begin
        send_beat(pmp_pkg::CMD_QUERY, 9'($urandom), 9'($urandom), $urandom, 1'b1,
                  19'($urandom_range(511 * 256, 262143)), 19'($urandom_range(0, 262143)));
      end else if (r < 97) begin
        send_beat(pmp_pkg::CMD_NONE, 9'($urandom), 9'($urandom), $urandom,
                  1'($urandom_range(0, 1)), 19'($urandom), 19'($urandom));
      end else begin
        wait_idle();
      end
    end
  endtask

  task automatic test_random_phases();
    set_regs(512, 512, 1920, 1080, 28'd20026328, 28'd11264787);
    random_burst(RANDOM_ITEMS / 6);
    set_regs(512, 512, 4095, 4095, 28'd65536, 28'd32768);
    no_gaps = 1'b1;
    random_burst(RANDOM_ITEMS / 6);
    no_gaps = 1'b0;
    set_regs(24, 20, 1, 1, 28'd0, 28'd0);
    random_burst(RANDOM_ITEMS / 6);
    set_regs(1023, 1023, 4095, 4095, 28'hFFF_FFFF, 28'hFFF_FFFF);
    random_burst(RANDOM_ITEMS / 6);
    set_regs($urandom_range(2, 512), $urandom_range(2, 512), $urandom_range(1, 4095),
             $urandom_range(1, 4095), 28'($urandom_range(0, 1 << 24)),
             28'($urandom_range(0, 1 << 24)));
    random_burst(RANDOM_ITEMS / 6);
    set_regs(40, 40, 2048, 1024, 28'd4000000, 28'd2000000);
    random_burst(RANDOM_ITEMS / 6);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_register_extremes();
    test_random_phases();
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d beats, checked %0d points (%0d valid) over six register settings",
             beats_sent, points_checked, valid_points);
    if (mismatches == 0 && expected_points.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_points.size());
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
